// File: hw/rtl/rpp_pkg.sv
// Shared types, constants, sine table and arithmetic helpers for the point rotate/project plotter.
`default_nettype none

package rpp_pkg;

    localparam int unsigned ANGLE_STEPS   = 512;
    localparam int unsigned ANGLE_BITS    = $clog2(ANGLE_STEPS);
    localparam int unsigned HALF_STEPS    = ANGLE_STEPS / 2;
    localparam logic [ANGLE_BITS-1:0] QUARTER_STEPS = ANGLE_BITS'(ANGLE_STEPS / 4);
    localparam longint     PI_Q30         = 64'sd3373259426;

    localparam int unsigned QUO_BITS      = 12;
    localparam int unsigned DIV_PER_STAGE = 3;
    localparam int unsigned DIV_STAGES    = QUO_BITS / DIV_PER_STAGE;

    localparam logic [9:0]  RST_BASE_DISTANCE    = 10'd300;
    localparam logic [9:0]  RST_PROJECTION_SCALE = 10'd256;
    localparam logic [11:0] RST_NEAR_CLIP        = 12'd64;
    localparam logic [13:0] RST_BLOOM_FAR        = 14'd800;
    localparam logic [13:0] RST_BLOOM_NEAR       = 14'd400;

    typedef enum logic [2:0] {
        CFG_BASE_DISTANCE    = 3'd0,
        CFG_PROJECTION_SCALE = 3'd1,
        CFG_NEAR_CLIP        = 3'd2,
        CFG_BLOOM_FAR        = 3'd3,
        CFG_BLOOM_NEAR       = 3'd4
    } t_cfg_idx;

    typedef logic signed [12:0] t_in_coord;
    typedef logic signed [15:0] t_coord;
    typedef logic signed [13:0] t_trig;
    typedef logic [12:0]        t_sine_mag;
    typedef t_sine_mag          t_half_table [HALF_STEPS];

    typedef struct packed {
        logic [24:0]         rem;
        logic [QUO_BITS-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic        keep;
        logic        far;
        logic        near;
        logic        neg_x;
        logic        neg_y;
        logic        ov_x;
        logic        ov_y;
        logic [15:0] den;
        logic [15:0] col;
        t_div_lane   lx;
        t_div_lane   ly;
    } t_div_stage;

    // floor(4096*sin(x)), x in Q30 radians within the first quadrant
    function automatic t_sine_mag sine_first(longint x);
        longint unsigned ux;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned p;
        longint          sum;
        ux   = unsigned'(x);
        x2   = (ux * ux) >> 30;
        term = ux;
        sum  = x;
        for (int k = 1; k <= 7; k++) begin
            p = (term * x2) >> 30;
            case (k)
                1:       term = p / 64'd6;
                2:       term = p / 64'd20;
                3:       term = p / 64'd42;
                4:       term = p / 64'd72;
                5:       term = p / 64'd110;
                6:       term = p / 64'd156;
                default: term = p / 64'd210;
            endcase
            if ((k & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64) >>> 18;
        if (sum > 4096) begin
            sum = 4096;
        end
        return 13'(sum);
    endfunction

    // First half turn; second half is the exact negation
    function automatic t_half_table build_half_table();
        t_half_table tbl;
        longint      x;
        for (int i = 0; i < int'(HALF_STEPS); i++) begin
            x = (longint'(i) * 2 * PI_Q30) >>> ANGLE_BITS;
            if (x > PI_Q30 / 2) begin
                x = PI_Q30 - x;
            end
            tbl[i] = sine_first(x);
        end
        return tbl;
    endfunction

    localparam t_half_table HALF_SINE = build_half_table();

    function automatic t_trig sin_at(logic [ANGLE_BITS-1:0] a);
        t_trig m;
        m = {1'b0, HALF_SINE[a[ANGLE_BITS-2:0]]};
        return a[ANGLE_BITS-1] ? -m : m;
    endfunction

    function automatic t_trig cos_at(logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS-1:0] b;
        b = a + QUARTER_STEPS;
        return sin_at(b);
    endfunction

    // (a*c - b*s) >>> 12
    function automatic t_coord rot_re(t_coord a, t_coord b, t_trig s, t_trig c);
        logic signed [30:0] acc;
        acc = 31'(a) * 31'(c) - 31'(b) * 31'(s);
        return 16'(acc >>> 12);
    endfunction

    // (a*s + b*c) >>> 12
    function automatic t_coord rot_im(t_coord a, t_coord b, t_trig s, t_trig c);
        logic signed [30:0] acc;
        acc = 31'(a) * 31'(s) + 31'(b) * 31'(c);
        return 16'(acc >>> 12);
    endfunction

    // Restoring division steps for quotient bits top .. top-DIV_PER_STAGE+1
    function automatic t_div_lane div_steps(t_div_lane v, logic [15:0] d, int unsigned top);
        t_div_lane   r;
        logic [27:0] dd;
        int unsigned b;
        r = v;
        for (int unsigned j = 0; j < DIV_PER_STAGE; j++) begin
            b  = top - j;
            dd = 28'(d) << b;
            if ({3'b000, r.rem} >= dd) begin
                r.rem    = 25'({3'b000, r.rem} - dd);
                r.quo[b] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/point_rotate_project_plot.sv
// Point rotate/project/plot pipeline: three rotations, depth clip, divide, bloom pixel emit.
// Path: input register, sine lookups, rotations, depth offset, divider stages, output register.
// Throughput: one point per cycle unless stalled; a point with n pixels (1 to 4) holds the
// output register until its last pixel transfers, and the whole pipeline stalls behind it.
// Divide: 12-bit quotient over four pipeline stages, three restoring steps each.
// Reset: synchronous active low; clears valid bits and restores register defaults.
`default_nettype none

module point_rotate_project_plot #(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 240
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [2:0]             i_cfg_idx,
    input  wire logic [13:0]            i_cfg_data,
    input  wire logic                   i_in_valid,
    output      logic                   o_in_ready,
    input  wire logic signed [12:0]     i_point_x,
    input  wire logic signed [12:0]     i_point_y,
    input  wire logic signed [12:0]     i_point_z,
    input  wire logic [15:0]            i_point_color,
    input  wire logic [6:0]             i_spin_rate,
    input  wire logic [14:0]            i_frame_tick,
    output      logic                   o_out_valid,
    input  wire logic                   i_out_ready,
    output      logic [8:0]             o_pixel_x,
    output      logic [7:0]             o_pixel_y,
    output      logic [15:0]            o_pixel_color,
    output      logic                   o_last_pixel
);

    localparam int unsigned AB = rpp_pkg::ANGLE_BITS;
    localparam int unsigned DS = rpp_pkg::DIV_STAGES;
    localparam logic signed [13:0] HALF_W = 14'(SCREEN_WIDTH / 2);
    localparam logic signed [13:0] HALF_H = 14'(SCREEN_HEIGHT / 2);
    localparam logic signed [13:0] SCR_W  = 14'(SCREEN_WIDTH);
    localparam logic signed [13:0] SCR_H  = 14'(SCREEN_HEIGHT);

    // configuration
    logic [9:0]  r_cfg_base;
    logic [9:0]  r_cfg_scale;
    logic [11:0] r_cfg_near_clip;
    logic [13:0] r_cfg_bloom_far;
    logic [13:0] r_cfg_bloom_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base       <= rpp_pkg::RST_BASE_DISTANCE;
            r_cfg_scale      <= rpp_pkg::RST_PROJECTION_SCALE;
            r_cfg_near_clip  <= rpp_pkg::RST_NEAR_CLIP;
            r_cfg_bloom_far  <= rpp_pkg::RST_BLOOM_FAR;
            r_cfg_bloom_near <= rpp_pkg::RST_BLOOM_NEAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpp_pkg::CFG_BASE_DISTANCE:    r_cfg_base       <= i_cfg_data[9:0];
                rpp_pkg::CFG_PROJECTION_SCALE: r_cfg_scale      <= i_cfg_data[9:0];
                rpp_pkg::CFG_NEAR_CLIP:        r_cfg_near_clip  <= i_cfg_data[11:0];
                rpp_pkg::CFG_BLOOM_FAR:        r_cfg_bloom_far  <= i_cfg_data;
                rpp_pkg::CFG_BLOOM_NEAR:       r_cfg_bloom_near <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: output register free or its last pixel transfers now
    logic       w_en;
    logic       r_o_vld;
    logic [3:0] r_o_mask;
    logic       w_last;
    logic       w_xfer;

    assign w_last     = (r_o_mask & (r_o_mask - 4'd1)) == 4'd0;
    assign w_xfer     = r_o_vld & i_out_ready;
    assign w_en       = !r_o_vld || (i_out_ready && w_last);
    assign o_in_ready = w_en;

    // stage 1: input register, spin angle
    logic [21:0]                spin_prod;
    logic                       r_v1;
    rpp_pkg::t_in_coord         r_s1_x, r_s1_y, r_s1_z;
    logic [15:0]                r_s1_col;
    logic [AB:0]                r_s1_tick;
    logic [AB-1:0]              r_s1_spin;

    assign spin_prod = {7'd0, i_frame_tick} * {15'd0, i_spin_rate};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
        end
        if (w_en) begin
            r_s1_x    <= i_point_x;
            r_s1_y    <= i_point_y;
            r_s1_z    <= i_point_z;
            r_s1_col  <= i_point_color;
            r_s1_tick <= i_frame_tick[AB:0];
            r_s1_spin <= spin_prod[AB+5:6];
        end
    end

    // stage 2: sine lookups
    logic               r_v2;
    rpp_pkg::t_in_coord r_s2_x, r_s2_y, r_s2_z;
    logic [15:0]        r_s2_col;
    rpp_pkg::t_trig     r_s2_s1, r_s2_c1, r_s2_st, r_s2_ct, r_s2_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
        if (w_en) begin
            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_z   <= r_s1_z;
            r_s2_col <= r_s1_col;
            r_s2_s1  <= rpp_pkg::sin_at(r_s1_spin);
            r_s2_c1  <= rpp_pkg::cos_at(r_s1_spin);
            r_s2_st  <= rpp_pkg::sin_at(r_s1_tick[AB-1:0]);
            r_s2_ct  <= rpp_pkg::cos_at(r_s1_tick[AB-1:0]);
            r_s2_sh  <= rpp_pkg::sin_at(r_s1_tick[AB:1]);
        end
    end

    // stage 3: spin rotation, pitch lookup, camera distance
    logic [AB-1:0]      pitch_idx;
    logic signed [11:0] cam_dist;
    logic               r_v3;
    rpp_pkg::t_coord    r_s3_x, r_s3_z, r_s3_y, r_s3_dist16;
    logic [15:0]        r_s3_col;
    rpp_pkg::t_trig     r_s3_sp, r_s3_cp, r_s3_st, r_s3_ct;

    assign pitch_idx = AB'(r_s2_st >>> 6);
    assign cam_dist  = $signed({2'b00, r_cfg_base}) + 12'(r_s2_sh >>> 5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
        if (w_en) begin
            r_s3_x      <= rpp_pkg::rot_re(16'(r_s2_x), 16'(r_s2_z), r_s2_s1, r_s2_c1);
            r_s3_z      <= rpp_pkg::rot_im(16'(r_s2_x), 16'(r_s2_z), r_s2_s1, r_s2_c1);
            r_s3_y      <= 16'(r_s2_y);
            r_s3_dist16 <= 16'(cam_dist) <<< 4;
            r_s3_col    <= r_s2_col;
            r_s3_sp     <= rpp_pkg::sin_at(pitch_idx);
            r_s3_cp     <= rpp_pkg::cos_at(pitch_idx);
            r_s3_st     <= r_s2_st;
            r_s3_ct     <= r_s2_ct;
        end
    end

    // stage 4: pitch rotation
    logic            r_v4;
    rpp_pkg::t_coord r_s4_x, r_s4_y, r_s4_z, r_s4_dist16;
    logic [15:0]     r_s4_col;
    rpp_pkg::t_trig  r_s4_st, r_s4_ct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
        if (w_en) begin
            r_s4_y      <= rpp_pkg::rot_re(r_s3_y, r_s3_z, r_s3_sp, r_s3_cp);
            r_s4_z      <= rpp_pkg::rot_im(r_s3_y, r_s3_z, r_s3_sp, r_s3_cp);
            r_s4_x      <= r_s3_x;
            r_s4_dist16 <= r_s3_dist16;
            r_s4_col    <= r_s3_col;
            r_s4_st     <= r_s3_st;
            r_s4_ct     <= r_s3_ct;
        end
    end

    // stage 5: yaw rotation
    logic            r_v5;
    rpp_pkg::t_coord r_s5_x, r_s5_y, r_s5_z, r_s5_dist16;
    logic [15:0]     r_s5_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= r_v4;
        end
        if (w_en) begin
            r_s5_x      <= rpp_pkg::rot_re(r_s4_x, r_s4_z, r_s4_st, r_s4_ct);
            r_s5_z      <= rpp_pkg::rot_im(r_s4_x, r_s4_z, r_s4_st, r_s4_ct);
            r_s5_y      <= r_s4_y;
            r_s5_dist16 <= r_s4_dist16;
            r_s5_col    <= r_s4_col;
        end
    end

    // stage 6: depth offset, scaled numerators
    logic signed [26:0] scale_s;
    logic               r_v6;
    logic signed [17:0] r_s6_zd;
    logic signed [26:0] r_s6_nx, r_s6_ny;
    logic [15:0]        r_s6_col;

    assign scale_s = 27'($signed({1'b0, r_cfg_scale}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_v5;
        end
        if (w_en) begin
            r_s6_zd  <= 18'(r_s5_z) + 18'(r_s5_dist16);
            r_s6_nx  <= 27'(r_s5_x) * scale_s;
            r_s6_ny  <= 27'(r_s5_y) * scale_s;
            r_s6_col <= r_s5_col;
        end
    end

    // stage 7 and divider stages
    rpp_pkg::t_div_stage r_dstage [DS+1];
    rpp_pkg::t_div_stage n_dstage [DS+1];
    logic [DS:0]         r_dv;
    logic [24:0]         mag_x, mag_y;
    logic [15:0]         den;

    assign mag_x = r_s6_nx[26] ? 25'(-r_s6_nx) : 25'(r_s6_nx);
    assign mag_y = r_s6_ny[26] ? 25'(-r_s6_ny) : 25'(r_s6_ny);
    assign den   = r_s6_zd[15:0];

    always_comb begin
        n_dstage[0].keep   = r_s6_zd > $signed({6'd0, r_cfg_near_clip});
        n_dstage[0].far    = r_s6_zd < $signed({4'd0, r_cfg_bloom_far});
        n_dstage[0].near   = r_s6_zd < $signed({4'd0, r_cfg_bloom_near});
        n_dstage[0].neg_x  = r_s6_nx[26];
        n_dstage[0].neg_y  = r_s6_ny[26];
        n_dstage[0].ov_x   = {3'b000, mag_x} >= {den, 12'd0};
        n_dstage[0].ov_y   = {3'b000, mag_y} >= {den, 12'd0};
        n_dstage[0].den    = den;
        n_dstage[0].col    = r_s6_col;
        n_dstage[0].lx.rem = mag_x;
        n_dstage[0].lx.quo = '0;
        n_dstage[0].ly.rem = mag_y;
        n_dstage[0].ly.quo = '0;
        for (int k = 1; k <= int'(DS); k++) begin
            n_dstage[k]    = r_dstage[k-1];
            n_dstage[k].lx = rpp_pkg::div_steps(r_dstage[k-1].lx, r_dstage[k-1].den,
                                 rpp_pkg::QUO_BITS - 1 - (k - 1) * rpp_pkg::DIV_PER_STAGE);
            n_dstage[k].ly = rpp_pkg::div_steps(r_dstage[k-1].ly, r_dstage[k-1].den,
                                 rpp_pkg::QUO_BITS - 1 - (k - 1) * rpp_pkg::DIV_PER_STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_en) begin
            r_dv <= {r_dv[DS-1:0], r_v6};
        end
        if (w_en) begin
            for (int k = 0; k <= int'(DS); k++) begin
                r_dstage[k] <= n_dstage[k];
            end
        end
    end

    // screen mapping and pixel mask
    logic signed [13:0] q_x, q_y, scr_x, scr_y;
    logic               on_scr, right, below;
    logic [3:0]         n_mask;

    always_comb begin
        q_x = {2'b00, r_dstage[DS].lx.quo};
        q_y = {2'b00, r_dstage[DS].ly.quo};
        if (r_dstage[DS].neg_x) begin
            q_x = -q_x;
        end
        if (r_dstage[DS].neg_y) begin
            q_y = -q_y;
        end
        scr_x  = HALF_W + q_x;
        scr_y  = HALF_H + q_y;
        on_scr = r_dstage[DS].keep && !r_dstage[DS].ov_x && !r_dstage[DS].ov_y
              && scr_x >= 14'sd0 && scr_x < SCR_W && scr_y >= 14'sd0 && scr_y < SCR_H;
        right  = scr_x < SCR_W - 14'sd1;
        below  = scr_y < SCR_H - 14'sd1;
        if (on_scr) begin
            n_mask = {r_dstage[DS].far && r_dstage[DS].near && right && below,
                      r_dstage[DS].far && below,
                      r_dstage[DS].far && right,
                      1'b1};
        end else begin
            n_mask = 4'd0;
        end
    end

    // output register
    logic [10:0] r_o_sx, r_o_sy;
    logic [15:0] r_o_col;
    logic [3:0]  lowbit;
    logic [10:0] out_x, out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld  <= 1'b0;
            r_o_mask <= 4'd0;
        end else if (w_en) begin
            r_o_vld  <= r_dv[DS] && (n_mask != 4'd0);
            r_o_mask <= r_dv[DS] ? n_mask : 4'd0;
        end else if (w_xfer) begin
            r_o_mask <= r_o_mask & (r_o_mask - 4'd1);
        end
        if (w_en) begin
            r_o_sx  <= scr_x[10:0];
            r_o_sy  <= scr_y[10:0];
            r_o_col <= r_dstage[DS].col;
        end
    end

    assign lowbit        = r_o_mask & (~r_o_mask + 4'd1);
    assign out_x         = r_o_sx + {10'd0, lowbit[1] | lowbit[3]};
    assign out_y         = r_o_sy + {10'd0, lowbit[2] | lowbit[3]};
    assign o_out_valid   = r_o_vld;
    assign o_pixel_x     = out_x[8:0];
    assign o_pixel_y     = out_y[7:0];
    assign o_pixel_color = r_o_col;
    assign o_last_pixel  = w_last;

`ifndef SYNTHESIS
    a_mask_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_o_mask != 4'd0)
        else $error("output valid with empty pixel mask");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_last_pixel == $onehot(r_o_mask))
        else $error("last pixel flag disagrees with mask");

    a_mask_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_pixel) |=>
        (o_out_valid && ($countones(r_o_mask) + 1 == $countones($past(r_o_mask)))))
        else $error("pixel transfer did not retire exactly one pixel");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_dv[DS]) |=> r_dv[DS])
        else $error("stalled point lost at divider output");
`endif

endmodule

`default_nettype wire

// File: tb/point_rotate_project_plot_test.sv
// Self-checking testbench for the point rotate/project/plot pipeline with its own pixel predictor.
`default_nettype none

module point_rotate_project_plot_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 320;
    localparam int H = 240;
    localparam int STEPS = 512;
    localparam longint PI30 = 64'sd3373259426;
    localparam logic [2:0] CFG_SPARE = 3'd5;
    localparam logic [2:0] CFG_TOP_SPARE = 3'd7;
    localparam int WATCHDOG = 4000;
    localparam int DRAIN_WAIT = 24;

    typedef struct {
        logic signed [12:0] x;
        logic signed [12:0] y;
        logic signed [12:0] z;
        logic [15:0] color;
        logic [6:0] rate;
        logic [14:0] tick;
    } t_point;

    typedef struct {
        logic [8:0] px;
        logic [7:0] py;
        logic [15:0] color;
        logic last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [13:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [12:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic [15:0] i_point_color = '0;
    logic [6:0] i_spin_rate = '0;
    logic [14:0] i_frame_tick = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [8:0] o_pixel_x;
    logic [7:0] o_pixel_y;
    logic [15:0] o_pixel_color;
    logic o_last_pixel;

    point_rotate_project_plot i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    longint sine_tbl[STEPS];
    longint cam_base, cam_scale, cam_near_clip, cam_bloom_far, cam_bloom_near;

    t_point pending_points[$];
    t_pixel expected_pixels[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int mismatches = 0;
    int points_sent = 0, pixels_seen = 0, dark_points = 0, full_bloom = 0;
    int quiet_cycles = 0;

    function automatic longint sine_first_q(longint x);
        longint unsigned ux, x2, term;
        longint sum;
        ux = unsigned'(x);
        x2 = (ux * ux) >> 30;
        term = ux;
        sum = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64) >>> 18;
        if (sum > 4096) begin
            sum = 4096;
        end
        return sum;
    endfunction

    function automatic longint sin_of(longint a);
        return sine_tbl[a & (STEPS - 1)];
    endfunction

    function automatic void turn(inout longint a, inout longint b, input longint ang);
        longint s, c, na, nb;
        s = sin_of(ang);
        c = sin_of(ang + STEPS / 4);
        na = (a * c - b * s) >>> 12;
        nb = (a * s + b * c) >>> 12;
        a = na;
        b = nb;
    endfunction

    function automatic void add_pixel(longint sx, longint sy, logic [15:0] col);
        t_pixel p;
        p.px = sx[8:0];
        p.py = sy[7:0];
        p.color = col;
        p.last = 1'b0;
        expected_pixels.push_back(p);
    endfunction

    function automatic void plot_point(t_point p);
        longint x, y, z, tick, pitch, cam_dist, sx, sy;
        bit right, below;
        x = p.x;
        y = p.y;
        z = p.z;
        tick = p.tick;
        pitch = sin_of(tick) >>> 6;
        cam_dist = cam_base + (sin_of(tick >> 1) >>> 5);
        turn(x, z, (tick * longint'(p.rate)) >> 6);
        turn(y, z, pitch);
        turn(x, z, tick);
        z = z + cam_dist * 16;
        if (z <= cam_near_clip) begin
            dark_points++;
            return;
        end
        sx = W / 2 + (x * cam_scale) / z;
        sy = H / 2 + (y * cam_scale) / z;
        if (sx < 0 || sx >= W || sy < 0 || sy >= H) begin
            dark_points++;
            return;
        end
        add_pixel(sx, sy, p.color);
        if (z < cam_bloom_far) begin
            right = sx + 1 < W;
            below = sy + 1 < H;
            if (right) begin
                add_pixel(sx + 1, sy, p.color);
            end
            if (below) begin
                add_pixel(sx, sy + 1, p.color);
            end
            if (z < cam_bloom_near && right && below) begin
                add_pixel(sx + 1, sy + 1, p.color);
                full_bloom++;
            end
        end
        expected_pixels[$].last = 1'b1;
    endfunction

    // sender
    always @(posedge i_clk) begin
        t_point nxt;
        bit busy;
        busy = i_in_valid;
        if (i_in_valid && o_in_ready) begin
            points_sent++;
            plot_point(pending_points.pop_front());
            busy = 1'b0;
        end
        if (!busy) begin
            if (i_rst_n && pending_points.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_points[0];
                i_in_valid <= 1'b1;
                i_point_x <= nxt.x;
                i_point_y <= nxt.y;
                i_point_z <= nxt.z;
                i_point_color <= nxt.color;
                i_spin_rate <= nxt.rate;
                i_frame_tick <= nxt.tick;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 300;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_pixel e;
        if (o_out_valid && i_out_ready && i_rst_n) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected pixel x=%0d y=%0d", o_pixel_x, o_pixel_y);
                end
            end else begin
                e = expected_pixels.pop_front();
                if (e.px !== o_pixel_x || e.py !== o_pixel_y ||
                    e.color !== o_pixel_color || e.last !== o_last_pixel) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"pixel mismatch exp x=%0d y=%0d c=%h l=%b ",
                                  "got x=%0d y=%0d c=%h l=%b"},
                                 e.px, e.py, e.color, e.last,
                                 o_pixel_x, o_pixel_y, o_pixel_color, o_last_pixel);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (pending_points.size() == 0 && expected_pixels.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("timeout");
            $display("[point_rotate_project_plot] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_points.size() != 0 || i_in_valid || expected_pixels.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [13:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rpp_pkg::CFG_BASE_DISTANCE: cam_base = val[9:0];
            rpp_pkg::CFG_PROJECTION_SCALE: cam_scale = val[9:0];
            rpp_pkg::CFG_NEAR_CLIP: cam_near_clip = val[11:0];
            rpp_pkg::CFG_BLOOM_FAR: cam_bloom_far = val;
            rpp_pkg::CFG_BLOOM_NEAR: cam_bloom_near = val;
            default: ;
        endcase
    endtask

    task automatic setup(int b, int s, int nc, int bf, int bn);
        write_reg(rpp_pkg::CFG_BASE_DISTANCE, 14'(b));
        write_reg(rpp_pkg::CFG_PROJECTION_SCALE, 14'(s));
        write_reg(rpp_pkg::CFG_NEAR_CLIP, 14'(nc));
        write_reg(rpp_pkg::CFG_BLOOM_FAR, 14'(bf));
        write_reg(rpp_pkg::CFG_BLOOM_NEAR, 14'(bn));
    endtask

    task automatic queue_point(int x, int y, int z, int c, int r, int t);
        t_point p;
        p.x = 13'(x);
        p.y = 13'(y);
        p.z = 13'(z);
        p.color = 16'(c);
        p.rate = 7'(r);
        p.tick = 15'(t);
        pending_points.push_back(p);
    endtask

    // mostly modest coordinates so that many points land on screen
    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                queue_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                queue_point($urandom_range(1200) - 600, $urandom_range(600) - 300,
                            $urandom_range(1200) - 600, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        longint xr;
        bit neg;
        for (int i = 0; i < STEPS; i++) begin
            xr = (longint'(i) * 2 * PI30) / STEPS;
            neg = 1'b0;
            if (xr > PI30) begin
                neg = 1'b1;
                xr = xr - PI30;
            end
            if (xr > PI30 / 2) begin
                xr = PI30 - xr;
            end
            if (xr < 0) begin
                xr = 0;
            end
            sine_tbl[i] = neg ? -sine_first_q(xr) : sine_first_q(xr);
        end
        cam_base = 300;
        cam_scale = 256;
        cam_near_clip = 64;
        cam_bloom_far = 800;
        cam_bloom_near = 400;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values
        send_idle_pct = 38;
        recv_idle_pct = 74;
        queue_point(0, 0, 0, 16'h0000, 0, 0);
        queue_point(4095, 4095, 4095, 16'hFFFF, 127, 32767);
        queue_point(-4096, -4096, -4096, 16'hA5A5, 127, 0);
        queue_point(-4096, 4095, 0, 16'h5A5A, 0, 32767);
        queue_point(100, -50, 200, 16'h1234, 1, 1);
        queue_point(0, 0, 4095, 16'h8001, 64, 128);
        queue_point(0, 0, -4096, 16'h7FFE, 64, 384);
        queue_point(300, 200, 0, 16'hF00F, 3, 256);
        queue_point(-300, -200, 0, 16'h0FF0, 5, 16384);
        queue_point(10, 10, 10, 16'hCAFE, 100, 511);
        wait_drained();
        // near camera, full bloom, negative distance offset
        setup(0, 1023, 0, 16383, 16383);
        write_reg(CFG_SPARE, 14'h3FFF);
        write_reg(CFG_TOP_SPARE, 14'h0);
        queue_point(0, 0, 0, 16'h1111, 0, 0);
        queue_point(500, 300, 0, 16'h2222, 0, 0);
        queue_point(-20, -20, 1000, 16'h3333, 0, 0);
        queue_point(4095, 0, 0, 16'h4444, 0, 0);
        queue_point(0, 100, 2000, 16'h5555, 7, 64);
        queue_point(-2000, -500, -3000, 16'h6666, 9, 200);
        queue_point(40, 30, 0, 16'h7777, 0, 0);
        queue_random(15);
        wait_drained();
        // far camera, no scale, no bloom
        setup(1023, 0, 4095, 0, 0);
        send_idle_pct = 74;
        recv_idle_pct = 38;
        queue_random(15);
        wait_drained();
        // bloom heavy, long receiver hold while the sender keeps offering
        setup(40, 700, 100, 16383, 8000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_token <= hold_token + 1;
        queue_random(25);
        wait_drained();
        setup($urandom_range(1023), $urandom_range(1023), $urandom_range(4095),
              $urandom_range(16383), $urandom_range(16383));
        queue_random(15);
        wait_drained();
        setup(300, 256, 64, 800, 400);
        queue_random(10);
        wait_drained();
        queue_random(12);
        wait_drained();

        $display("%0d points sent over six register settings, %0d pixels checked,", points_sent,
                 pixels_seen);
        $display("%0d points dark, %0d with full bloom", dark_points, full_bloom);
        if (mismatches == 0) begin
            $display("[point_rotate_project_plot] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[point_rotate_project_plot] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/rpp_pkg.sv
hw/rtl/point_rotate_project_plot.sv
tb/point_rotate_project_plot_test.sv
